### src/qpat_pkg.sv
package qpat_pkg;

  localparam int SampleBits = 16;

  typedef struct packed {
    logic                         operation;
    logic signed [SampleBits-1:0] sample_a;
    logic signed [SampleBits-1:0] sample_b;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] angle;
    logic signed [31:0] speed;
    logic               started;
  } out_item_t;

  localparam int CordicSteps = 24;
  localparam logic signed [63:0] QuarterTurn = 64'sd1073741824;
  localparam logic signed [63:0] CordicGainQ30 = 64'sd652032875;
  localparam logic signed [31:0] Inv2PiQ24 = 32'sd2670178;

  localparam logic [1:0] RegKp = 2'd0;
  localparam logic [1:0] RegKi = 2'd1;
  localparam logic [1:0] RegTs = 2'd2;
  localparam logic [1:0] RegK  = 2'd3;

  function automatic logic signed [63:0] atan_entry(input logic [4:0] i);
    logic signed [63:0] r;
    begin
      case (i)
        5'd0: r = 64'sd536870912;  5'd1: r = 64'sd316933405;
        5'd2: r = 64'sd167458907;  5'd3: r = 64'sd85004756;
        5'd4: r = 64'sd42667331;   5'd5: r = 64'sd21354465;
        5'd6: r = 64'sd10679838;   5'd7: r = 64'sd5340245;
        5'd8: r = 64'sd2670163;    5'd9: r = 64'sd1335086;
        5'd10: r = 64'sd667544;    5'd11: r = 64'sd333772;
        5'd12: r = 64'sd166886;    5'd13: r = 64'sd83443;
        5'd14: r = 64'sd41721;     5'd15: r = 64'sd20860;
        5'd16: r = 64'sd10430;     5'd17: r = 64'sd5215;
        5'd18: r = 64'sd2607;      5'd19: r = 64'sd1303;
        5'd20: r = 64'sd651;       5'd21: r = 64'sd325;
        5'd22: r = 64'sd162;       5'd23: r = 64'sd81;
        default: r = 64'sd0;
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    begin
      if (v > 64'sd2147483647) r = 32'sh7fffffff;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
    end
  endfunction

endpackage

### src/qpat_cordic.sv
// shared cordic: vectoring (atan2) or rotation (sin/cos), one step a cycle
module qpat_cordic (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                vector_i,
  input  logic signed [63:0]  x_i,
  input  logic signed [63:0]  y_i,
  input  logic signed [63:0]  z_i,
  output logic                done_o,
  output logic signed [63:0]  x_o,
  output logic signed [63:0]  y_o,
  output logic signed [63:0]  z_o
);
  import qpat_pkg::*;

  logic signed [63:0] x_q, y_q, z_q;
  logic [4:0] step_q;
  logic busy_q, vec_q, done_q;
  logic dir_neg;
  logic signed [63:0] dx, dy, at;

  assign dx = y_q >>> step_q;
  assign dy = x_q >>> step_q;
  assign at = atan_entry(step_q);
  // rotate towards zero residual: vectoring looks at y, rotation at z
  assign dir_neg = vec_q ? (y_q < 0) : !(z_q < 0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      vec_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
        vec_q  <= vector_i;
      end else if (busy_q) begin
        if (step_q == 5'(CordicSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x_i;
      y_q <= y_i;
      z_q <= z_i;
    end else if (busy_q) begin
      if (dir_neg) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
    end
  end

  assign done_o = done_q;
  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
endmodule

### src/quadrature_pll_angle_tracker_unit.sv
// quadrature pll angle tracker
// a restart goes straight to the result; a first sample runs the shared
// cordic as atan2, a tracking sample runs it as sin/cos, then error,
// integral, proportional, speed filter (when on) and phase step; one item at
// a time (24 cordic and 7-8 multiply steps); in_stall_o is high while busy
// reset (async, active low) clears tracking state and loads register defaults
module quadrature_pll_angle_tracker_unit #(
  parameter int ANGLE_BITS  = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  qpat_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output qpat_pkg::out_item_t out_data_o
);
  import qpat_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001, S_CORD = 8'b00000010, S_ERR  = 8'b00000100,
    S_INT  = 8'b00001000, S_PROP = 8'b00010000, S_FILT = 8'b00100000,
    S_STEP = 8'b01000000, S_OUT  = 8'b10000000
  } state_e;

  state_e state_q;
  logic [31:0] kp_q, ki_q, ts_q;
  logic [15:0] fk_q;
  logic [ANGLE_BITS-1:0] acc_q;
  logic signed [31:0] spd_q, integ_q, filt_q, raw_q;
  logic started_q, first_q, flip_q, sub_q, ovalid_q;
  logic signed [SampleBits-1:0] a_q, b_q;
  logic signed [63:0] err_q, p_q, d_q;
  logic [1:0] sub_step_q;

  logic cord_start, cord_vec, cord_done;
  logic signed [63:0] cx_i, cy_i, cz_i, cx, cy, cz;
  logic signed [SampleBits-1:0] a_in, b_in;
  logic in_xfer;

  assign in_xfer = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE) || ovalid_q;
  assign a_in = in_data_i.sample_a;
  assign b_in = in_data_i.sample_b;

  // cordic seed: quadrant fold for atan2, half-turn fold for sin/cos
  logic signed [63:0] xs, ys, za;
  logic [31:0] a32;
  logic flip_d;
  always_comb begin
    xs = 64'(a_in) <<< (40 - SampleBits);
    ys = xs;
    xs = 64'(b_in) <<< (40 - SampleBits);
    a32 = 32'(acc_q) << (32 - ANGLE_BITS);
    za = 64'(signed'(a32));
    flip_d = 1'b0;
    cord_vec = !started_q;
    cx_i = xs; cy_i = ys; cz_i = '0;
    if (cord_vec) begin
      if (xs < 0) begin
        if (ys >= 0) begin
          cx_i = ys; cy_i = -xs; cz_i = 64'(QuarterTurn);
        end else begin
          cx_i = -ys; cy_i = xs; cz_i = -64'(QuarterTurn);
        end
      end
    end else begin
      cx_i = CordicGainQ30; cy_i = '0; cz_i = za;
      if (za > 64'(QuarterTurn)) begin
        cz_i = za - 64'(2 * QuarterTurn); flip_d = 1'b1;
      end else if (za < -64'(QuarterTurn)) begin
        cz_i = za + 64'(2 * QuarterTurn); flip_d = 1'b1;
      end
    end
  end

  assign cord_start = in_xfer && !in_data_i.operation;

  qpat_cordic u_cordic (
    .clk_i, .rst_ni, .start_i(cord_start), .vector_i(cord_vec),
    .x_i(cx_i), .y_i(cy_i), .z_i(cz_i), .done_o(cord_done),
    .x_o(cx), .y_o(cy), .z_o(cz)
  );

  // shared 34x34 multiplier, one product per sequencer step
  // the turn conversion splits r into a low 20-bit and a high part
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod_full;
  logic signed [63:0] prod, d_sum;
  logic signed [63:0] c_v, s_v;
  assign c_v = flip_q ? -cx : cx;
  assign s_v = flip_q ? -cy : cy;
  always_comb begin
    mul_a = '0; mul_b = '0;
    unique case (state_q)
      S_ERR:  begin
        mul_a = sub_q ? 34'(b_q) : 34'(a_q);
        mul_b = sub_q ? 34'(s_v) : 34'(c_v);
      end
      S_INT:  begin mul_a = 34'(err_q); mul_b = signed'({2'b00, ki_q}); end
      S_PROP: begin mul_a = 34'(err_q); mul_b = signed'({2'b00, kp_q}); end
      S_FILT: begin
        mul_a = 34'(raw_q) - 34'(filt_q); mul_b = signed'({18'd0, fk_q});
      end
      S_STEP: begin
        case (sub_step_q)
          2'd0: begin mul_a = 34'(spd_q); mul_b = signed'({2'b00, ts_q}); end
          2'd1: begin
            mul_a = signed'({14'd0, p_q[19:0]}); mul_b = 34'(Inv2PiQ24);
          end
          default: begin mul_a = 34'(p_q >>> 20); mul_b = 34'(Inv2PiQ24); end
        endcase
      end
      default: ;
    endcase
  end
  assign prod_full = mul_a * mul_b;
  assign prod = 64'(prod_full);
  // full turn product: high part shifted into place plus the low part
  assign d_sum = (prod <<< 20) + d_q;

  logic signed [31:0] raw_v;
  always_comb begin
    raw_v = sat32(64'(integ_q) + (prod >>> 24));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kp_q <= '0; ki_q <= '0; ts_q <= 32'd1; fk_q <= '0;
      acc_q <= '0; spd_q <= '0; integ_q <= '0; filt_q <= '0;
      started_q <= 1'b0; ovalid_q <= 1'b0;
      sub_q <= 1'b0; sub_step_q <= '0; first_q <= 1'b0; flip_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegKp: kp_q <= cfg_data_i;
          RegKi: ki_q <= cfg_data_i;
          RegTs: ts_q <= cfg_data_i;
          RegK:  fk_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (in_xfer) begin
          a_q <= a_in; b_q <= b_in;
          if (in_data_i.operation) begin
            acc_q <= '0; spd_q <= '0; integ_q <= '0; filt_q <= '0;
            started_q <= 1'b0; state_q <= S_OUT;
          end else begin
            first_q <= !started_q; flip_q <= flip_d;
            state_q <= S_CORD;
          end
        end
        S_CORD: if (cord_done) begin
          if (first_q) begin
            acc_q <= (a_q == 0 && b_q == 0) ? '0 : cz[31 -: ANGLE_BITS];
            spd_q <= '0; integ_q <= '0; started_q <= 1'b1;
            state_q <= S_OUT;
          end else begin
            sub_q <= 1'b0; state_q <= S_ERR;
          end
        end
        S_ERR: begin
          if (!sub_q) begin err_q <= prod; sub_q <= 1'b1; end
          else begin
            err_q <= (err_q - prod) >>> (SampleBits + 5);
            state_q <= S_INT;
          end
        end
        S_INT: begin
          integ_q <= sat32(64'(integ_q) + (prod >>> 24)); state_q <= S_PROP;
        end
        S_PROP: begin
          raw_q <= raw_v;
          if (fk_q != 0) state_q <= S_FILT;
          else begin spd_q <= raw_v; state_q <= S_STEP; sub_step_q <= '0; end
        end
        S_FILT: begin
          filt_q <= sat32(64'(filt_q) + (prod >>> 16));
          spd_q <= sat32(64'(filt_q) + (prod >>> 16));
          sub_step_q <= '0; state_q <= S_STEP;
        end
        S_STEP: begin
          if (sub_step_q == 2'd0) begin
            p_q <= prod >>> 24; sub_step_q <= 2'd1;
          end else if (sub_step_q == 2'd1) begin
            d_q <= prod; sub_step_q <= 2'd2;
          end else begin
            acc_q <= acc_q + ANGLE_BITS'(d_sum >>> (48 - ANGLE_BITS));
            state_q <= S_OUT;
          end
        end
        S_OUT: begin ovalid_q <= 1'b1; state_q <= S_IDLE; end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o.angle = acc_q[ANGLE_BITS-1 -: 16];
  assign out_data_o.speed = spd_q;
  assign out_data_o.started = started_q;
endmodule

### src/qpat_checker.sv
module qpat_props (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input qpat_pkg::out_item_t out_data_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while stalled");
  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken with result pending");
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o) else $error("no busy after transfer");
endmodule

bind quadrature_pll_angle_tracker_unit qpat_props u_chk (.*);

### tb/qpat_checker.sv
`timescale 1ns / 1ps

module qpat_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  qpat_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  qpat_pkg::out_item_t out_data_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  checked_o
);
  import qpat_pkg::*;

  localparam longint QTurn = 64'sd1073741824;

  // tracker state as predicted
  logic [31:0]        phase_acc;
  logic signed [31:0] speed_q;
  logic signed [31:0] integ_q;
  logic signed [31:0] lpf_q;
  logic               locked;
  logic [31:0]        kp_q, ki_q, ts_q;
  logic [15:0]        k_q;

  out_item_t expected_q[$];

  function automatic longint fshift(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint arctab(input int i);
    longint tab[24] = '{536870912, 316933405, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335086, 667544, 333772, 166886,
      83443, 41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162, 81};
    return tab[i];
  endfunction

  // atan2 by vectoring cordic, 2^32 per turn
  function automatic logic [31:0] phase_of(input longint ya, input longint xb);
    longint x, y, z, t, dx, dy;
    x = xb * 64'sd16777216; y = ya * 64'sd16777216; z = 0;
    if (xb == 0 && ya == 0) return 32'd0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = QTurn;
      end else begin
        x = -y; y = t; z = -QTurn;
      end
    end
    for (int i = 0; i < 24; i++) begin
      dx = fshift(y, i); dy = fshift(x, i);
      if (y < 0) begin
        x -= dx; y += dy; z -= arctab(i);
      end else begin
        x += dx; y -= dy; z += arctab(i);
      end
    end
    return z[31:0];
  endfunction

  // rotation cordic, q1.30 outputs
  task automatic rotate(input logic [31:0] ph, output longint c, output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'($signed(ph)); x = 652032875; y = 0; flip = 0;
    if (z > QTurn) begin
      z -= 2 * QTurn; flip = 1;
    end else if (z < -QTurn) begin
      z += 2 * QTurn; flip = 1;
    end
    for (int i = 0; i < 24; i++) begin
      dx = fshift(y, i); dy = fshift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctab(i);
      end else begin
        x += dx; y -= dy; z += arctab(i);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x; s = y;
  endtask

  task automatic track_sample(input in_item_t it);
    longint a, b, c, s, err, raw, p, r, d;
    out_item_t res;
    a = longint'(it.sample_a);
    b = longint'(it.sample_b);
    if (it.operation) begin
      phase_acc = 0; speed_q = 0; integ_q = 0; lpf_q = 0; locked = 0;
    end else if (!locked) begin
      phase_acc = phase_of(a, b);
      speed_q = 0; integ_q = 0; locked = 1;
    end else begin
      rotate(phase_acc, c, s);
      err = fshift(a * c - b * s, 21);
      integ_q = 32'(clamp32(longint'(integ_q) + fshift(err * longint'(ki_q), 24)));
      raw = clamp32(longint'(integ_q) + fshift(err * longint'(kp_q), 24));
      if (k_q != 0) begin
        lpf_q = 32'(clamp32(longint'(lpf_q) +
                            fshift((raw - longint'(lpf_q)) * longint'(k_q), 16)));
        speed_q = lpf_q;
      end else begin
        speed_q = 32'(raw);
      end
      p = longint'(speed_q) * longint'(ts_q);
      r = fshift(p, 24);
      d = r * 2670178;
      phase_acc = 32'(longint'(phase_acc) + fshift(d, 16));
    end
    res.angle = phase_acc[31:16];
    res.speed = speed_q;
    res.started = locked;
    expected_q.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_item;
    if (!rst_ni) begin
      phase_acc <= 0; speed_q <= 0; integ_q <= 0; lpf_q <= 0; locked <= 0;
      kp_q <= 0; ki_q <= 0; ts_q <= 32'd1; k_q <= 0;
      fail_count_o <= 0; checked_o <= 0; pending_o <= 0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegKp: kp_q = cfg_data_i;
          RegKi: ki_q = cfg_data_i;
          RegTs: ts_q = cfg_data_i;
          RegK:  k_q = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) track_sample(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        checked_o <= checked_o + 1;
        if (expected_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result transfer %p", out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_item = expected_q.pop_front();
          if (exp_item !== out_data_i) begin
            if (fail_count_o < 10)
              $display("mismatch: expected angle %0d speed %0d started %0b, got %0d %0d %0b",
                       exp_item.angle, exp_item.speed, exp_item.started,
                       out_data_i.angle, out_data_i.speed, out_data_i.started);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= expected_q.size();
    end
  end
endmodule

### tb/tb_quadrature_pll_angle_tracker_unit.sv
`timescale 1ns / 1ps

module tb_quadrature_pll_angle_tracker_unit;
  import qpat_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we = 0;
  logic [1:0]  cfg_idx = RegKp;
  logic [31:0] cfg_data = 0;
  logic        in_valid = 0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 0;
  out_item_t   out_data;
  int          fail_count, pending, checked;
  longint      cycles = 0;
  int          phase_count = 0;

  always #5 clk_i = ~clk_i;
  always @(posedge clk_i) cycles <= cycles + 1;

  quadrature_pll_angle_tracker_unit u_top (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  qpat_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  // receiver stall: a drawn wait per result, none in some phases
  initial begin : rx_proc
    int wait_n;
    forever begin
      wait_n = (phase_count % 3 == 1) ? 0 : $urandom_range(0, 12);
      out_stall <= (wait_n != 0);
      repeat (wait_n) @(posedge clk_i);
      out_stall <= 0;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  // one transfer on the input channel, after a random gap when gaps is set
  task automatic send(input logic op, input logic [15:0] a, input logic [15:0] b,
                      input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1;
    in_data <= '{operation: op, sample_a: a, sample_b: b};
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we <= 1; cfg_idx <= idx; cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // sample pair on a circle with noise, amplitude random
  task automatic tone(input int phase_deg, output logic [15:0] a, output logic [15:0] b);
    real amp, th;
    amp = $urandom_range(2000, 32000);
    th = phase_deg * 3.14159265358979 / 180.0;
    a = 16'($rtoi(amp * $sin(th)) + int'($urandom_range(0, 400)) - 200);
    b = 16'($rtoi(amp * $cos(th)) + int'($urandom_range(0, 400)) - 200);
  endtask

  logic [15:0] sa, sb;
  int          ph, w;

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: restart, zero first sample, field extremes, reset and extreme registers
    send(1, 0, 0, 0);
    send(0, 0, 0, 0);
    send(0, 16'h7fff, 16'h8000, 0);
    send(1, 16'h8000, 16'h7fff, 0);
    send(0, 16'h8000, 16'h8000, 0);
    send(0, 16'h7fff, 16'h7fff, 0);
    send(0, 16'hffff, 16'h0001, 0);
    drain();
    write_reg(RegKp, 32'hffff_ffff);
    write_reg(RegKi, 32'hffff_ffff);
    write_reg(RegTs, 32'hffff_ffff);
    write_reg(RegK, 32'h0000_ffff);
    send(0, 16'h7fff, 16'h8000, 1);
    send(0, 16'h8000, 16'h7fff, 1);
    send(0, 16'h8000, 16'h8000, 1);
    send(0, 16'h7fff, 16'h0000, 1);
    send(1, 16'h5555, 16'haaaa, 1);
    send(0, 16'h0000, 16'h8000, 1);
    send(0, 16'h8000, 16'h0000, 1);
    drain();
    write_reg(RegTs, 32'd0);
    write_reg(RegK, 32'd1);
    send(0, 16'h1234, 16'h4321, 1);
    send(0, 16'hedcb, 16'hbcde, 1);
    drain();

    // random phases with varied settings
    for (int p = 0; p < 16; p++) begin
      phase_count = p;
      write_reg(RegKp, (p % 4 == 0) ? $urandom : $urandom_range(0, 32'h0004_0000));
      write_reg(RegKi, (p % 5 == 0) ? $urandom : $urandom_range(0, 32'h0000_4000));
      write_reg(RegTs, (p % 6 == 0) ? $urandom : $urandom_range(1, 32'h0010_0000));
      write_reg(RegK, (p % 3 == 0) ? 32'd0 : $urandom_range(0, 65535));
      ph = $urandom_range(0, 359);
      w = int'($urandom_range(0, 20)) - 10;
      for (int i = 0; i < 125; i++) begin
        if ($urandom_range(0, 99) < 3) begin
          send(1, 16'($urandom), 16'($urandom), p % 3 != 1);
        end else if ($urandom_range(0, 99) < 15) begin
          send(0, 16'($urandom), 16'($urandom), p % 3 != 1);
        end else begin
          tone(ph, sa, sb);
          send(0, sa, sb, p % 3 != 1);
          ph = (ph + w + 360) % 360;
        end
      end
      drain();
    end

    $display("covered 16 register settings, restarts, extremes and tracked tones");
    $display("results checked: %0d", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (cycles > 1000000) begin
      $display("tb: failure");
      $finish;
    end
  end
endmodule

### quadrature_pll_angle_tracker_unit.f
src/qpat_pkg.sv
src/qpat_cordic.sv
src/quadrature_pll_angle_tracker_unit.sv
src/qpat_checker.sv
tb/qpat_checker.sv
tb/tb_quadrature_pll_angle_tracker_unit.sv
